// ===== src/wfr_pkg.sv =====
`timescale 1ns / 1ps

package wfr_pkg;

  // Width of the frame shift register and of its bit pointer.
  localparam int WORD_BITS = 32;
  localparam int POS_W     = $clog2(WORD_BITS);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EVEN_MASK      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ODD_MASK       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FACILITY_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FACILITY_SHIFT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USER_MASK      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_USER_SHIFT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [5:0]  RST_FRAME_LENGTH   = 6'd26;
  localparam logic [31:0] RST_EVEN_MASK      = 32'h01FF_E000;
  localparam logic [31:0] RST_ODD_MASK       = 32'h0000_1FFE;
  localparam logic [31:0] RST_FACILITY_MASK  = 32'h01FE_0000;
  localparam logic [4:0]  RST_FACILITY_SHIFT = 5'd17;
  localparam logic [31:0] RST_USER_MASK      = 32'h0001_FFFE;
  localparam logic [4:0]  RST_USER_SHIFT     = 5'd1;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd20;

  // Input command codes.
  localparam logic CMD_BIT  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes.
  localparam logic STATUS_CARD_VALID = 1'b0;
  localparam logic STATUS_PARITY_ERR = 1'b1;

  typedef struct packed {
    logic command;
    logic bit_value;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [15:0] facility_code;
    logic [15:0] user_id;
    logic [31:0] swipe_total;
    logic [31:0] parity_fail_total;
  } out_word_t;

  typedef struct packed {
    logic [5:0]  frame_length;
    logic [31:0] even_field_mask;
    logic [31:0] odd_field_mask;
    logic [31:0] facility_mask;
    logic [4:0]  facility_shift;
    logic [31:0] user_mask;
    logic [4:0]  user_shift;
    logic [15:0] timeout_ticks;
  } cfg_t;

  // Position of the first (top) bit of a frame for a given length.
  // A length of zero acts as one, a length above the word acts as the word.
  function automatic logic [POS_W-1:0] top_position(input logic [5:0] len);
    logic [POS_W-1:0] pos;
    if (len == 6'd0) begin
      pos = '0;
    end else if (32'(len) > WORD_BITS) begin
      pos = POS_W'(WORD_BITS - 1);
    end else begin
      pos = POS_W'(len - 6'd1);
    end
    return pos;
  endfunction

endpackage

// ===== src/wfr_cfg_regs.sv =====
`timescale 1ns / 1ps

module wfr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wfr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output wfr_pkg::cfg_t                 cfg_o
);
  import wfr_pkg::*;

  cfg_t cfg_q;

  // Register file; each write updates the addressed register only.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length    <= RST_FRAME_LENGTH;
      cfg_q.even_field_mask <= RST_EVEN_MASK;
      cfg_q.odd_field_mask  <= RST_ODD_MASK;
      cfg_q.facility_mask   <= RST_FACILITY_MASK;
      cfg_q.facility_shift  <= RST_FACILITY_SHIFT;
      cfg_q.user_mask       <= RST_USER_MASK;
      cfg_q.user_shift      <= RST_USER_SHIFT;
      cfg_q.timeout_ticks   <= RST_TIMEOUT_TICKS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_LENGTH:   cfg_q.frame_length    <= cfg_wdata_i[5:0];
        REG_EVEN_MASK:      cfg_q.even_field_mask <= cfg_wdata_i[31:0];
        REG_ODD_MASK:       cfg_q.odd_field_mask  <= cfg_wdata_i[31:0];
        REG_FACILITY_MASK:  cfg_q.facility_mask   <= cfg_wdata_i[31:0];
        REG_FACILITY_SHIFT: cfg_q.facility_shift  <= cfg_wdata_i[4:0];
        REG_USER_MASK:      cfg_q.user_mask       <= cfg_wdata_i[31:0];
        REG_USER_SHIFT:     cfg_q.user_shift      <= cfg_wdata_i[4:0];
        REG_TIMEOUT_TICKS:  cfg_q.timeout_ticks   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/wfr_input_stage.sv =====
`timescale 1ns / 1ps

module wfr_input_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wfr_pkg::in_word_t in_data_i,
  output logic              stage_valid_o,
  input  logic              stage_ready_i,
  output wfr_pkg::in_word_t stage_data_o
);
  import wfr_pkg::*;

  logic     valid_q, valid_d;
  in_word_t data_q;

  // The register takes a new word when it is empty or its word moves on.
  assign in_ready_o = !valid_q || stage_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign stage_data_o  = data_q;

endmodule

// ===== src/wfr_frame_core.sv =====
`timescale 1ns / 1ps

module wfr_frame_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wfr_pkg::cfg_t      cfg_i,
  input  logic               fire_i,
  input  wfr_pkg::in_word_t  data_i,
  output logic               res_valid_o,
  output wfr_pkg::out_word_t res_data_o
);
  import wfr_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [15:0]          idle_q, idle_d;
  logic [31:0]          swipe_q, swipe_d;
  logic [31:0]          fail_q, fail_d;

  logic [POS_W-1:0]     top_pos;
  logic [WORD_BITS-1:0] shifted_word;
  logic                 even_ok, odd_ok, good;
  logic [WORD_BITS-1:0] fac_field, user_field;
  logic [15:0]          idle_inc, limit;

  assign top_pos = top_position(cfg_i.frame_length);

  // Frame word with the incoming bit placed at the current position.
  assign shifted_word = word_q | (WORD_BITS'(data_i.bit_value) << pos_q);

  // Leading even parity on the top bit, trailing odd parity on bit 0.
  assign even_ok = shifted_word[top_pos] ==
                   ^(shifted_word & WORD_BITS'(cfg_i.even_field_mask));
  assign odd_ok  = shifted_word[0] ==
                   ~^(shifted_word & WORD_BITS'(cfg_i.odd_field_mask));
  assign good    = even_ok && odd_ok;

  assign fac_field  = (shifted_word & WORD_BITS'(cfg_i.facility_mask)) >> cfg_i.facility_shift;
  assign user_field = (shifted_word & WORD_BITS'(cfg_i.user_mask)) >> cfg_i.user_shift;

  // Idle tick counter saturates; a zero timeout behaves as one tick.
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign limit    = (cfg_i.timeout_ticks == 16'd0) ? 16'd1 : cfg_i.timeout_ticks;

  // Next state and the result of the word being processed.
  always_comb begin
    word_d      = word_q;
    pos_d       = pos_q;
    idle_d      = idle_q;
    swipe_d     = swipe_q;
    fail_d      = fail_q;
    res_valid_o = 1'b0;
    if (fire_i) begin
      if (data_i.command == CMD_TICK) begin
        idle_d = idle_inc;
        if (idle_inc >= limit) begin
          word_d = '0;
          pos_d  = top_pos;
          idle_d = '0;
        end
      end else begin
        idle_d = '0;
        if (pos_q != '0) begin
          word_d = shifted_word;
          pos_d  = pos_q - POS_W'(1);
        end else begin
          res_valid_o = 1'b1;
          if (swipe_q != 32'hFFFF_FFFF) begin
            swipe_d = swipe_q + 32'd1;
          end
          if (!good && fail_q != 32'hFFFF_FFFF) begin
            fail_d = fail_q + 32'd1;
          end
          word_d = '0;
          pos_d  = top_pos;
        end
      end
    end
  end

  always_comb begin
    res_data_o.status            = good ? STATUS_CARD_VALID : STATUS_PARITY_ERR;
    res_data_o.facility_code     = good ? 16'(fac_field) : 16'd0;
    res_data_o.user_id           = good ? 16'(user_field) : 16'd0;
    res_data_o.swipe_total       = swipe_d;
    res_data_o.parity_fail_total = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      pos_q   <= top_position(RST_FRAME_LENGTH);
      idle_q  <= '0;
      swipe_q <= '0;
      fail_q  <= '0;
    end else begin
      word_q  <= word_d;
      pos_q   <= pos_d;
      idle_q  <= idle_d;
      swipe_q <= swipe_d;
      fail_q  <= fail_d;
    end
  end

endmodule

// ===== src/wiegand_frame_receiver.sv =====
`timescale 1ns / 1ps

// Wiegand frame receiver.
// Input channel (in_valid_i / in_ready_o / in_data_i): one word per D0/D1
// bit event or per millisecond tick. Bits arrive MSB first.
// Output channel (out_valid_o / out_ready_i / out_data_o): one word per
// completed frame with parity status, facility code, user id and the
// saturating swipe and parity-failure totals.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i in the
// same edge; write only while no word is in flight.
// Path: a frame's last bit passes the input register, then the result
// register, before it shows on the output.
// Throughput: one input word per cycle while out_ready_i does not stall; the
// frame logic between the input and result registers is a single combinational pass.
// Stalls: while a result waits for out_ready_i, the input register holds
// its word and in_ready_o drops once that register is full.
// Reset: all but the data registers load defaults, the frame restarts at the
// top position of a 26-bit frame, and both totals clear.
module wiegand_frame_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wfr_pkg::in_word_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wfr_pkg::out_word_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [wfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import wfr_pkg::*;

  cfg_t      cfg;
  logic      stage_valid, stage_ready, fire;
  in_word_t  stage_data;
  logic      res_valid;
  out_word_t res_data;
  logic      out_valid_q, out_valid_d;
  out_word_t out_data_q;

  wfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wfr_input_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .stage_valid_o (stage_valid),
    .stage_ready_i (stage_ready),
    .stage_data_o  (stage_data)
  );

  // A word is processed when the result register can take its result.
  assign stage_ready = !out_valid_q || out_ready_i;
  assign fire        = stage_valid && stage_ready;

  wfr_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .data_i      (stage_data),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (stage_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
